// File: design/rpfs_pkg.sv
`timescale 1ns / 1ps
package rpfs_pkg;
   localparam int MAX_POINTS = 1024;
   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam logic [63:0] ERR_RESET = 64'd16777216000000000000;
   localparam logic [62:0] ERR_CAP = {63{1'b1}};

   localparam logic [1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_MIN_INLIERS = 2'd1;
   localparam logic [1:0] CSR_HYP_COUNT = 2'd2;

   typedef struct packed {
      logic        kind;
      logic        first_point;
      logic [31:0] point_x;
      logic [31:0] point_y;
      logic [31:0] point_z;
      logic [9:0]  sample_first;
      logic [9:0]  sample_second;
      logic [9:0]  sample_third;
   } req_type;

   typedef struct packed {
      logic [31:0] plane_a;
      logic [31:0] plane_c;
      logic [31:0] plane_d;
      logic [62:0] best_error;
      logic [10:0] inlier_count;
      logic        found;
      logic        updated;
      logic        rejected;
      logic        round_done;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_RD0, ST_RD1, ST_RD2, ST_LAT2, ST_DIFF, ST_DEN, ST_DEN2,
      ST_DIVA, ST_WAITA, ST_DIVC, ST_WAITC, ST_D1, ST_D2, ST_D3, ST_N2,
      ST_SCAN_RD, ST_SCAN_LAT, ST_R1, ST_R2, ST_R3, ST_R4, ST_SQ, ST_DV,
      ST_DVW, ST_ACC, ST_FINISH
   } state_type;

   typedef struct packed {
      logic        start;
      logic [63:0] num;
      logic [63:0] den;
      logic [6:0]  frac;
      logic [63:0] lim;
   } div_req_type;

   function automatic logic [63:0] mag64(input logic signed [63:0] v);
      mag64 = v[63] ? 64'(-v) : v;
   endfunction

   function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (!a[63] && !b[63] && s[63]) sat_add64 = {1'b0, {63{1'b1}}};
      else if (a[63] && b[63] && !s[63]) sat_add64 = {1'b1, 63'd0};
      else sat_add64 = s;
   endfunction

   function automatic logic signed [63:0] sat_sub64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a - b;
      if (!a[63] && b[63] && s[63]) sat_sub64 = {1'b0, {63{1'b1}}};
      else if (a[63] && !b[63] && !s[63]) sat_sub64 = {1'b1, 63'd0};
      else sat_sub64 = s;
   endfunction

   function automatic logic [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) sat32 = 32'h7fffffff;
      else if (v < -64'sd2147483648) sat32 = 32'h80000000;
      else sat32 = v[31:0];
   endfunction
endpackage

// File: design/rpfs_ram.sv
`timescale 1ns / 1ps
module rpfs_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// File: design/rpfs_div.sv
`timescale 1ns / 1ps
// floor(num * 2^frac / den) capped at lim, one quotient bit per cycle.
// Integer part is taken by restoring division over 64 bits first.
module rpfs_div
   import rpfs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output logic        done,
   output logic [63:0] quot
);
   logic        busy_ff, busy_in;
   logic [6:0]  step_ff, step_in;
   logic [6:0]  frac_ff, frac_in;
   logic        phase_ff, phase_in;
   logic [64:0] rem_ff, rem_in;
   logic [63:0] num_ff, num_in;
   logic [63:0] den_ff, den_in;
   logic [63:0] q_ff, q_in;
   logic [63:0] lim_ff, lim_in;
   logic        sat_ff, sat_in;
   logic        done_ff, done_in;
   logic [64:0] trial;
   logic [64:0] dbl;

   always_comb begin
      busy_in = busy_ff; step_in = step_ff; frac_in = frac_ff; phase_in = phase_ff;
      rem_in = rem_ff; num_in = num_ff; den_in = den_ff; q_in = q_ff;
      lim_in = lim_ff; sat_in = sat_ff; done_in = 1'b0;
      trial = {rem_ff[63:0], num_ff[63]};
      dbl = {rem_ff[63:0], 1'b0};
      if (req.start) begin
         busy_in = 1'b1; step_in = 7'd0; phase_in = 1'b0; rem_in = '0;
         num_in = req.num; den_in = req.den; q_in = '0; lim_in = req.lim;
         frac_in = req.frac; sat_in = 1'b0;
      end else if (busy_ff) begin
         if (!phase_ff) begin
            num_in = {num_ff[62:0], 1'b0};
            if (trial >= {1'b0, den_ff}) begin
               rem_in = trial - {1'b0, den_ff};
               q_in = {q_ff[62:0], 1'b1};
            end else begin
               rem_in = trial;
               q_in = {q_ff[62:0], 1'b0};
            end
            step_in = step_ff + 7'd1;
            if (step_ff == 7'd63) begin
               phase_in = 1'b1; step_in = 7'd0;
            end
         end else begin
            if (q_ff > lim_ff) sat_in = 1'b1;
            if (sat_ff || q_ff > lim_ff || step_ff == frac_ff) begin
               busy_in = 1'b0; done_in = 1'b1;
               sat_in = sat_ff || q_ff > lim_ff;
            end else begin
               if (q_ff[63]) sat_in = 1'b1;
               if (dbl >= {1'b0, den_ff}) begin
                  rem_in = dbl - {1'b0, den_ff};
                  q_in = {q_ff[62:0], 1'b1};
               end else begin
                  rem_in = dbl;
                  q_in = {q_ff[62:0], 1'b0};
               end
               step_in = step_ff + 7'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
      step_ff <= step_in; frac_ff <= frac_in; phase_ff <= phase_in; rem_ff <= rem_in;
      num_ff <= num_in; den_ff <= den_in; q_ff <= q_in; lim_ff <= lim_in; sat_ff <= sat_in;
   end

   assign done = done_ff;
   assign quot = sat_ff ? lim_ff : q_ff;
endmodule

// File: design/ransac_plane_fit_scorer.sv
`timescale 1ns / 1ps
// Plane-fit scorer. A load beat writes one point into a 1024-entry point RAM (a
// non-first load is dropped once it is full) and returns nothing; busy stays low
// after it. A hypothesis beat reads its three samples, solves the plane with two
// serial divides, then scans every stored point, each through the serial distance
// divide. rsp_valid pulses for one cycle with the result and the receiver cannot
// stall it. start is ignored while busy is high.
module ransac_plane_fit_scorer
   import rpfs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  rpfs_pkg::req_type      req_data,
   output logic                   rsp_valid,
   output rpfs_pkg::rsp_type      rsp_data,
   input  logic                   csr_wr_en,
   input  logic [1:0]             csr_index,
   input  logic [30:0]            csr_wr_data
);
   state_type state_ff, state_in;
   logic [30:0] thr_ff;
   logic [10:0] min_ff;
   logic [15:0] hcnt_ff;
   logic [CNT_W-1:0] pcount_ff, pcount_in;
   logic signed [31:0] best_a_ff, best_a_in, best_c_ff, best_c_in, best_d_ff, best_d_in;
   logic [63:0] best_err_ff, best_err_in;
   logic found_ff, found_in;
   logic [15:0] round_ff, round_in;

   logic ram_we;
   logic [IDX_W-1:0] ram_waddr, ram_raddr;
   logic [95:0] ram_wdata, ram_rdata;

   req_type req_ff, req_in;
   logic signed [31:0] px_ff [3], px_in [3];
   logic signed [31:0] py_ff [3], py_in [3];
   logic signed [31:0] pz_ff [3], pz_in [3];
   logic signed [31:0] dx01_ff, dx12_ff, dy01_ff, dy12_ff, dz01_ff, dz12_ff;
   logic signed [31:0] dx01_in, dx12_in, dy01_in, dy12_in, dz01_in, dz12_in;
   logic signed [63:0] p0_ff, p1_ff, p2_ff, p3_ff, p0_in, p1_in, p2_in, p3_in;
   logic signed [63:0] den_ff, den_in, na_ff, na_in, nc_ff, nc_in;
   logic signed [31:0] a_ff, a_in, c_ff, c_in, d_ff, d_in;
   logic signed [63:0] acc_ff, acc_in;
   logic [63:0] n2_ff, n2_in, t2_ff, t2_in, r2_ff, r2_in, err_ff, err_in;
   logic [31:0] r_ff, r_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [10:0] inl_ff, inl_in;
   logic neg_ff, neg_in;
   logic rsp_v_ff, rsp_v_in;
   rsp_type rsp_ff, rsp_in;
   div_req_type dreq;
   logic div_done;
   logic [63:0] div_q;
   logic [63:0] mq;
   logic done_w;
   logic [63:0] err_sum;

   rpfs_ram #(.WIDTH(96), .DEPTH(MAX_POINTS)) u_ram (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(ram_wdata),
      .rd_addr(ram_raddr), .rd_data(ram_rdata));

   rpfs_div u_div (.clock(clock), .reset(reset), .req(dreq), .done(div_done), .quot(div_q));

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= 31'd65536; min_ff <= '0; hcnt_ff <= 16'd100;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_THRESHOLD:   thr_ff <= csr_wr_data;
            CSR_MIN_INLIERS: min_ff <= csr_wr_data[10:0];
            CSR_HYP_COUNT:   hcnt_ff <= csr_wr_data[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff; pcount_in = pcount_ff;
      best_a_in = best_a_ff; best_c_in = best_c_ff; best_d_in = best_d_ff;
      best_err_in = best_err_ff; found_in = found_ff; round_in = round_ff;
      req_in = req_ff;
      px_in = px_ff; py_in = py_ff; pz_in = pz_ff;
      dx01_in = dx01_ff; dx12_in = dx12_ff; dy01_in = dy01_ff; dy12_in = dy12_ff;
      dz01_in = dz01_ff; dz12_in = dz12_ff;
      p0_in = p0_ff; p1_in = p1_ff; p2_in = p2_ff; p3_in = p3_ff;
      den_in = den_ff; na_in = na_ff; nc_in = nc_ff;
      a_in = a_ff; c_in = c_ff; d_in = d_ff; acc_in = acc_ff;
      n2_in = n2_ff; t2_in = t2_ff; r2_in = r2_ff; err_in = err_ff; r_in = r_ff;
      idx_in = idx_ff; inl_in = inl_ff; neg_in = neg_ff;
      rsp_v_in = 1'b0; rsp_in = rsp_ff;
      ram_we = 1'b0; ram_waddr = pcount_ff[IDX_W-1:0];
      ram_wdata = {req_data.point_x, req_data.point_y, req_data.point_z};
      ram_raddr = idx_ff[IDX_W-1:0];
      dreq = '0;
      mq = div_q;
      done_w = ({16'd0, round_ff} + 32'd1) >= {16'd0, hcnt_ff};
      err_sum = err_ff + {8'd0, div_q[63:8]};
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_data;
               if (!req_data.kind) begin
                  if (req_data.first_point) begin
                     best_a_in = '0; best_c_in = '0; best_d_in = '0;
                     best_err_in = ERR_RESET; found_in = 1'b0; round_in = '0;
                  end
                  if (!req_data.first_point && pcount_ff < CNT_W'(MAX_POINTS)) begin
                     ram_we = 1'b1; pcount_in = pcount_ff + 1'b1;
                  end else if (req_data.first_point) begin
                     ram_we = 1'b1; ram_waddr = '0; pcount_in = CNT_W'(1);
                  end
               end else begin
                  ram_raddr = req_data.sample_first[IDX_W-1:0];
                  state_in = ST_RD0;
               end
            end
         end
         ST_RD0: begin ram_raddr = req_ff.sample_second[IDX_W-1:0]; state_in = ST_RD1;
            px_in[0] = ram_rdata[95:64]; py_in[0] = ram_rdata[63:32]; pz_in[0] = ram_rdata[31:0];
         end
         ST_RD1: begin ram_raddr = req_ff.sample_third[IDX_W-1:0]; state_in = ST_RD2;
            px_in[1] = ram_rdata[95:64]; py_in[1] = ram_rdata[63:32]; pz_in[1] = ram_rdata[31:0];
         end
         ST_RD2: begin state_in = ST_LAT2;
            px_in[2] = ram_rdata[95:64]; py_in[2] = ram_rdata[63:32]; pz_in[2] = ram_rdata[31:0];
         end
         ST_LAT2: state_in = ST_DIFF;
         ST_DIFF: begin
            dx01_in = sat32(64'(px_ff[0]) - 64'(px_ff[1]));
            dx12_in = sat32(64'(px_ff[1]) - 64'(px_ff[2]));
            dy01_in = sat32(64'(py_ff[0]) - 64'(py_ff[1]));
            dy12_in = sat32(64'(py_ff[1]) - 64'(py_ff[2]));
            dz01_in = sat32(64'(pz_ff[0]) - 64'(pz_ff[1]));
            dz12_in = sat32(64'(pz_ff[1]) - 64'(pz_ff[2]));
            state_in = ST_DEN;
         end
         ST_DEN: begin
            p0_in = dx01_ff * dz12_ff; p1_in = dx12_ff * dz01_ff;
            p2_in = dy01_ff * dz12_ff; p3_in = dy12_ff * dz01_ff;
            state_in = ST_DEN2;
         end
         ST_DEN2: begin
            den_in = p0_ff - p1_ff; na_in = p2_ff - p3_ff;
            p0_in = dx01_ff * dy12_ff; p1_in = dx12_ff * dy01_ff;
            state_in = ST_DIVA;
         end
         ST_DIVA: begin
            nc_in = p0_ff - p1_ff;
            if (den_ff == 0) begin
               inl_in = '0;
               rsp_in.updated = 1'b0; rsp_in.rejected = 1'b1;
               state_in = ST_FINISH;
            end else begin
               neg_in = na_ff[63] ^ den_ff[63];
               dreq.start = 1'b1; dreq.num = mag64(na_ff); dreq.den = mag64(den_ff);
               dreq.frac = 7'd16;
               dreq.lim = (na_ff[63] ^ den_ff[63]) ? 64'h80000000 : 64'h7fffffff;
               state_in = ST_WAITA;
            end
         end
         ST_WAITA: if (div_done) begin
            a_in = neg_ff ? 32'(-mq) : mq[31:0];
            state_in = ST_DIVC;
         end
         ST_DIVC: begin
            neg_in = nc_ff[63] ^ den_ff[63];
            dreq.start = 1'b1; dreq.num = mag64(nc_ff); dreq.den = mag64(den_ff);
            dreq.frac = 7'd16;
            dreq.lim = (nc_ff[63] ^ den_ff[63]) ? 64'h80000000 : 64'h7fffffff;
            state_in = ST_WAITC;
         end
         ST_WAITC: if (div_done) begin
            c_in = neg_ff ? 32'(-mq) : mq[31:0];
            state_in = ST_D1;
         end
         ST_D1: begin
            p0_in = a_ff * px_ff[0]; p1_in = c_ff * pz_ff[0];
            p2_in = a_ff * a_ff; p3_in = c_ff * c_ff;
            state_in = ST_D2;
         end
         ST_D2: begin
            acc_in = sat_sub64(64'(py_ff[0]) <<< 16, p0_ff);
            n2_in = p2_ff + p3_ff + 64'h100000000;
            t2_in = {33'd0, thr_ff} * {33'd0, thr_ff};
            state_in = ST_D3;
         end
         ST_D3: begin
            acc_in = sat_sub64(acc_ff, p1_ff);
            state_in = ST_N2;
         end
         ST_N2: begin
            // truncate toward zero
            d_in = sat32(acc_ff[63] ? -(mag64(acc_ff) >> 16) : (acc_ff >>> 16));
            idx_in = '0; inl_in = '0; err_in = '0;
            state_in = ST_SCAN_RD;
         end
         ST_SCAN_RD: begin
            if (idx_ff >= pcount_ff) state_in = ST_FINISH;
            else state_in = ST_SCAN_LAT;
         end
         ST_SCAN_LAT: state_in = ST_R1;
         ST_R1: begin
            p0_in = a_ff * $signed(ram_rdata[95:64]);
            p1_in = c_ff * $signed(ram_rdata[31:0]);
            p2_in = 64'($signed(ram_rdata[63:32])) <<< 16;
            state_in = ST_R2;
         end
         ST_R2: begin acc_in = sat_add64(p0_ff, p1_ff); state_in = ST_R3; end
         ST_R3: begin acc_in = sat_add64(acc_ff, 64'(d_ff) <<< 16); state_in = ST_R4; end
         ST_R4: begin
            acc_in = sat_sub64(acc_ff, p2_ff);
            state_in = ST_SQ;
         end
         ST_SQ: begin
            r_in = (mag64(acc_ff) >> 16) > 64'hffffffff ? 32'hffffffff
                   : 32'(mag64(acc_ff) >> 16);
            state_in = ST_DV;
         end
         ST_DV: begin
            r2_in = {32'd0, r_ff} * {32'd0, r_ff};
            state_in = ST_DVW;
         end
         ST_DVW: begin
            dreq.start = 1'b1; dreq.num = r2_ff; dreq.den = n2_ff; dreq.frac = 7'd32;
            dreq.lim = '1;
            state_in = ST_ACC;
         end
         ST_ACC: if (div_done) begin
            if (div_q < t2_ff) begin
               inl_in = inl_ff + 1'b1;
               err_in = (err_sum > {1'b0, ERR_CAP}) ? {1'b0, ERR_CAP} : err_sum;
            end
            idx_in = idx_ff + 1'b1;
            state_in = ST_SCAN_RD;
         end
         ST_FINISH: begin
            rsp_in.rejected = (den_ff == 0);
            rsp_in.updated = 1'b0;
            if (den_ff != 0 && inl_ff > min_ff) begin
               found_in = 1'b1;
               if (err_ff < best_err_ff) begin
                  best_a_in = a_ff; best_c_in = c_ff; best_d_in = d_ff;
                  best_err_in = err_ff; rsp_in.updated = 1'b1;
               end
            end
            round_in = done_w ? 16'd0 : round_ff + 16'd1;
            rsp_in.plane_a = best_a_in; rsp_in.plane_c = best_c_in;
            rsp_in.plane_d = best_d_in;
            rsp_in.best_error = (best_err_in > {1'b0, ERR_CAP}) ? ERR_CAP
                                : best_err_in[62:0];
            rsp_in.inlier_count = (den_ff == 0) ? 11'd0 : inl_ff;
            rsp_in.found = found_in;
            rsp_in.round_done = done_w;
            rsp_v_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; pcount_ff <= '0;
         best_a_ff <= '0; best_c_ff <= '0; best_d_ff <= '0;
         best_err_ff <= ERR_RESET; found_ff <= 1'b0; round_ff <= '0; rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in; pcount_ff <= pcount_in;
         best_a_ff <= best_a_in; best_c_ff <= best_c_in; best_d_ff <= best_d_in;
         best_err_ff <= best_err_in; found_ff <= found_in; round_ff <= round_in;
         rsp_v_ff <= rsp_v_in;
      end
      req_ff <= req_in; px_ff <= px_in; py_ff <= py_in; pz_ff <= pz_in;
      dx01_ff <= dx01_in; dx12_ff <= dx12_in; dy01_ff <= dy01_in; dy12_ff <= dy12_in;
      dz01_ff <= dz01_in; dz12_ff <= dz12_in;
      p0_ff <= p0_in; p1_ff <= p1_in; p2_ff <= p2_in; p3_ff <= p3_in;
      den_ff <= den_in; na_ff <= na_in; nc_ff <= nc_in;
      a_ff <= a_in; c_ff <= c_in; d_ff <= d_in; acc_ff <= acc_in;
      n2_ff <= n2_in; t2_ff <= t2_in; r2_ff <= r2_in; err_ff <= err_in; r_ff <= r_in;
      idx_ff <= idx_in; inl_ff <= inl_in; neg_ff <= neg_in; rsp_ff <= rsp_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_v_ff;
   assign rsp_data = rsp_ff;

   a_rsp_after_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_FINISH)) else $error("rsp without finish");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      pcount_ff <= CNT_W'(MAX_POINTS)) else $error("point count overflow");
   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.rejected |-> !rsp_data.updated && rsp_data.inlier_count == 0)
      else $error("rejected hypothesis updated");
endmodule

// File: verif/ransac_plane_fit_scorer_tb.sv
`timescale 1ns / 1ps
module ransac_plane_fit_scorer_tb;
   import rpfs_pkg::*;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_HYP = 1'b1;
   localparam longint CYCLE_LIMIT = 5000000;
   localparam longint S64_MAX = 64'sh7fffffffffffffff;
   localparam longint S64_MIN = 64'sh8000000000000000;

   typedef struct {
      req_type req;
      bit      has_exp;
      rsp_type exp;
   } stim_row_t;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    csr_wr_en = 1'b0;
   logic [1:0]  csr_index = CSR_THRESHOLD;
   logic [30:0] csr_wr_data = '0;

   ransac_plane_fit_scorer DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_wr_en(csr_wr_en),
      .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   // shadow of the block state
   int          pts_x[MAX_POINTS], pts_y[MAX_POINTS], pts_z[MAX_POINTS];
   int          pts_loaded, pts_written;
   int          best_a, best_c, best_d;
   bit [63:0]   best_err;
   bit          found_flag;
   int          round_ctr;
   bit [30:0]   thr_reg;
   bit [10:0]   min_inl_reg;
   bit [15:0]   hyp_cnt_reg;

   rsp_type     expected_scores[$];
   int          mismatches, failures, idle_pct;
   int          n_loads, n_hyps, n_rejects, n_updates, n_rsp;
   longint      cycles;
   stim_row_t   stim_rows[$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycles,
                  expected_scores.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic int clip32(input longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return int'(v);
   endfunction

   function automatic longint sadd(input longint a, input longint b);
      if (b > 0 && a > S64_MAX - b) return S64_MAX;
      if (b < 0 && a < S64_MIN - b) return S64_MIN;
      return a + b;
   endfunction

   function automatic longint ssub(input longint a, input longint b);
      if (b < 0 && a > S64_MAX + b) return S64_MAX;
      if (b > 0 && a < S64_MIN + b) return S64_MIN;
      return a - b;
   endfunction

   function automatic bit [63:0] absv(input longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   // floor(n * 2^f / d), clamped to lim
   function automatic bit [63:0] frac_div(input bit [63:0] n, input bit [63:0] d,
                                          input int f, input bit [63:0] lim);
      bit [63:0] q, r;
      q = n / d;
      r = n % d;
      if (q > lim) return lim;
      for (int i = 0; i < f; i++) begin
         q = q << 1;
         if (r >= d - r) begin
            r = r - (d - r);
            q[0] = 1'b1;
         end else begin
            r = r << 1;
         end
         if (q > lim) return lim;
      end
      return q;
   endfunction

   function automatic int slope_div(input longint n, input longint d);
      bit neg;
      bit [63:0] q;
      neg = (n < 0) != (d < 0);
      q = frac_div(absv(n), absv(d), 16, neg ? 64'h80000000 : 64'h7fffffff);
      return neg ? int'(-longint'(q)) : int'(q);
   endfunction

   function automatic void reset_scores();
      pts_loaded = 0;
      best_a = 0;
      best_c = 0;
      best_d = 0;
      best_err = ERR_RESET;
      found_flag = 1'b0;
      round_ctr = 0;
   endfunction

   // returns 1 with the score when the beat produces a result
   function automatic bit score_beat(input req_type r, output rsp_type o);
      int        s[3];
      longint    x[3], y[3], z[3];
      longint    dx01, dx12, dy01, dy12, dz01, dz12, den, acc;
      int        a, c, d, inl;
      bit [63:0] err, t2, n2, rr, r2, dist2;
      bit        upd, rej, done;
      o = '0;
      if (r.kind == KIND_LOAD) begin
         if (r.first_point) reset_scores();
         if (pts_loaded < MAX_POINTS) begin
            pts_x[pts_loaded] = r.point_x;
            pts_y[pts_loaded] = r.point_y;
            pts_z[pts_loaded] = r.point_z;
            pts_loaded++;
            if (pts_loaded > pts_written) pts_written = pts_loaded;
         end
         return 1'b0;
      end
      s[0] = r.sample_first;
      s[1] = r.sample_second;
      s[2] = r.sample_third;
      for (int k = 0; k < 3; k++) begin
         x[k] = pts_x[s[k]];
         y[k] = pts_y[s[k]];
         z[k] = pts_z[s[k]];
      end
      dx01 = clip32(x[0] - x[1]); dx12 = clip32(x[1] - x[2]);
      dy01 = clip32(y[0] - y[1]); dy12 = clip32(y[1] - y[2]);
      dz01 = clip32(z[0] - z[1]); dz12 = clip32(z[1] - z[2]);
      den = dx01 * dz12 - dx12 * dz01;
      inl = 0;
      err = 0;
      upd = 1'b0;
      rej = 1'b0;
      if (den == 0) begin
         rej = 1'b1;
      end else begin
         a = slope_div(dy01 * dz12 - dy12 * dz01, den);
         c = slope_div(dx01 * dy12 - dx12 * dy01, den);
         acc = ssub(y[0] * 65536, longint'(a) * x[0]);
         acc = ssub(acc, longint'(c) * z[0]);
         d = clip32(acc / 65536);
         t2 = 64'(thr_reg) * 64'(thr_reg);
         n2 = absv(longint'(a) * a) + absv(longint'(c) * c) + 64'h1_0000_0000;
         for (int i = 0; i < pts_loaded; i++) begin
            acc = sadd(longint'(a) * pts_x[i], longint'(c) * pts_z[i]);
            acc = sadd(acc, longint'(d) * 65536);
            acc = ssub(acc, longint'(pts_y[i]) * 65536);
            rr = absv(acc) / 65536;
            if (rr > 64'hffffffff) rr = 64'hffffffff;
            r2 = rr * rr;
            dist2 = frac_div(r2, n2, 32, '1);
            if (dist2 < t2) begin
               inl++;
               err = err + (dist2 >> 8);
               if (err > 64'(ERR_CAP)) err = 64'(ERR_CAP);
            end
         end
         if (inl > min_inl_reg) begin
            found_flag = 1'b1;
            if (err < best_err) begin
               best_a = a;
               best_c = c;
               best_d = d;
               best_err = err;
               upd = 1'b1;
            end
         end
      end
      done = (round_ctr + 1) >= hyp_cnt_reg;
      round_ctr = done ? 0 : ((round_ctr + 1) & 16'hffff);
      o.plane_a = best_a;
      o.plane_c = best_c;
      o.plane_d = best_d;
      o.best_error = best_err > 64'(ERR_CAP) ? ERR_CAP : best_err[62:0];
      o.inlier_count = inl > 2047 ? 11'd2047 : 11'(inl);
      o.found = found_flag;
      o.updated = upd;
      o.rejected = rej;
      o.round_done = done;
      n_rejects += rej;
      n_updates += upd;
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid) begin
         n_rsp++;
         if (expected_scores.size() == 0) begin
            failures++;
            $display("unexpected result %h", rsp_data);
         end else begin
            e = expected_scores.pop_front();
            if (e.plane_a !== rsp_data.plane_a || e.plane_c !== rsp_data.plane_c ||
                e.plane_d !== rsp_data.plane_d || e.best_error !== rsp_data.best_error ||
                e.inlier_count !== rsp_data.inlier_count || e.found !== rsp_data.found ||
                e.updated !== rsp_data.updated || e.rejected !== rsp_data.rejected ||
                e.round_done !== rsp_data.round_done) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch on result %0d:", n_rsp);
                  $display("  exp a=%h c=%h d=%h err=%h inl=%0d f=%b u=%b rj=%b rd=%b",
                           e.plane_a, e.plane_c, e.plane_d, e.best_error,
                           e.inlier_count, e.found, e.updated, e.rejected, e.round_done);
                  $display("  got a=%h c=%h d=%h err=%h inl=%0d f=%b u=%b rj=%b rd=%b",
                           rsp_data.plane_a, rsp_data.plane_c, rsp_data.plane_d,
                           rsp_data.best_error, rsp_data.inlier_count, rsp_data.found,
                           rsp_data.updated, rsp_data.rejected, rsp_data.round_done);
               end
            end
         end
      end
   end

   // called at a falling edge, returns at a falling edge after the beat is taken
   task automatic send_beat(input req_type r, input bit has_exp, input rsp_type exp_rsp);
      rsp_type o;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      if (score_beat(r, o)) begin
         n_hyps++;
         expected_scores.push_back(has_exp ? exp_rsp : o);
      end else begin
         n_loads++;
      end
      @(negedge clock);
   endtask

   task automatic send(input req_type r);
      send_beat(r, 1'b0, '0);
   endtask

   // let all outstanding work finish
   task automatic drain();
      start <= 1'b0;
      @(negedge clock);
      while (expected_scores.size() != 0 || busy) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_csrs(input bit [30:0] thr, input bit [10:0] mn, input bit [15:0] hc);
      bit [30:0] vals[3];
      logic [1:0] idx[3];
      vals = '{thr, 31'(mn), 31'(hc)};
      idx = '{CSR_THRESHOLD, CSR_MIN_INLIERS, CSR_HYP_COUNT};
      for (int i = 0; i < 3; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= idx[i];
         csr_wr_data <= vals[i];
         @(negedge clock);
      end
      csr_wr_en <= 1'b0;
      @(negedge clock);
      thr_reg = thr;
      min_inl_reg = mn;
      hyp_cnt_reg = hc;
   endtask

   function automatic req_type load_req(input bit first, input int x, input int y,
                                        input int z);
      req_type r;
      r = '0;
      r.kind = KIND_LOAD;
      r.first_point = first;
      r.point_x = x;
      r.point_y = y;
      r.point_z = z;
      r.sample_first = $urandom;
      r.sample_second = $urandom;
      r.sample_third = $urandom;
      return r;
   endfunction

   function automatic req_type hyp_req(input int i, input int j, input int k);
      req_type r;
      r.kind = KIND_HYP;
      r.first_point = $urandom;
      r.point_x = $urandom;
      r.point_y = $urandom;
      r.point_z = $urandom;
      r.sample_first = i;
      r.sample_second = j;
      r.sample_third = k;
      return r;
   endfunction

   function automatic void add_row(input req_type r, input bit has_exp, input rsp_type e);
      stim_row_t row;
      row.req = r;
      row.has_exp = has_exp;
      row.exp = e;
      stim_rows.push_back(row);
   endfunction

   function automatic req_type rand_hyp();
      return hyp_req($urandom_range(pts_written - 1), $urandom_range(pts_written - 1),
                     $urandom_range(pts_written - 1));
   endfunction

   // one plane-shaped point set with some outliers, then a burst of hypotheses
   task automatic plane_sequence();
      longint pa, pc, pd, px, pz, py;
      int     npts, nhyp;
      bit     junk;
      pa = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
      pc = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
      pd = $signed($urandom_range(0, 1 << 23)) - (1 << 22);
      npts = $urandom_range(3, 9);
      junk = $urandom_range(9) == 0;
      for (int i = 0; i < npts; i++) begin
         px = $signed($urandom_range(0, 1 << 19)) - (1 << 18);
         pz = $signed($urandom_range(0, 1 << 19)) - (1 << 18);
         py = ((pa * px + pc * pz) >>> 16) + pd + $signed($urandom_range(0, 512)) - 256;
         if (junk || $urandom_range(5) == 0)
            send(load_req(i == 0, $urandom, $urandom, $urandom));
         else
            send(load_req(i == 0, clip32(px), clip32(py), clip32(pz)));
      end
      nhyp = $urandom_range(2, 6);
      for (int h = 0; h < nhyp; h++) begin
         if ($urandom_range(4) == 0) send(rand_hyp());
         else send(hyp_req($urandom_range(npts - 1), $urandom_range(npts - 1),
                           $urandom_range(npts - 1)));
      end
   endtask

   initial begin
      rsp_type rej_fresh;
      int      total;
      cycles = 0;
      mismatches = 0;
      failures = 0;
      idle_pct = 15;
      n_loads = 0; n_hyps = 0; n_rejects = 0; n_updates = 0; n_rsp = 0;
      pts_written = 0;
      thr_reg = 31'd65536;
      min_inl_reg = 11'd0;
      hyp_cnt_reg = 16'd100;
      reset_scores();

      // a rejected sample on a fresh model reads back the reset best
      rej_fresh = '0;
      rej_fresh.best_error = ERR_CAP;
      rej_fresh.rejected = 1'b1;

      add_row(load_req(1'b1, 0, 0, 0), 1'b0, '0);
      add_row(hyp_req(0, 0, 0), 1'b1, rej_fresh);
      add_row(load_req(1'b0, 32'h00010000, 0, 0), 1'b0, '0);
      add_row(load_req(1'b0, 0, 0, 32'h00010000), 1'b0, '0);
      add_row(load_req(1'b0, 32'h00010000, 0, 32'h00010000), 1'b0, '0);
      add_row(load_req(1'b0, 32'h00020000, 32'h00008000, 32'h00020000), 1'b0, '0);
      add_row(load_req(1'b0, 32'h80000000, 32'h80000000, 32'h80000000), 1'b0, '0);
      add_row(load_req(1'b0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff), 1'b0, '0);
      add_row(load_req(1'b0, 32'h7fffffff, 32'h80000000, 32'h80000000), 1'b0, '0);
      add_row(hyp_req(0, 1, 2), 1'b0, '0);
      add_row(hyp_req(1, 2, 3), 1'b0, '0);
      add_row(hyp_req(0, 3, 4), 1'b0, '0);          // collinear in x-z: zero denominator
      add_row(hyp_req(5, 6, 0), 1'b0, '0);          // opposite extremes saturate
      add_row(hyp_req(6, 7, 1), 1'b0, '0);
      add_row(hyp_req(2, 1, 1), 1'b0, '0);
      add_row(hyp_req(4, 5, 7), 1'b0, '0);
      add_row(load_req(1'b1, 32'h00030000, 32'h00010000, 0), 1'b0, '0);
      add_row(hyp_req(0, 0, 0), 1'b1, rej_fresh);   // clear restored the reset best
      add_row(hyp_req(0, 1, 2), 1'b0, '0);          // index past the count reads stale data
      add_row(hyp_req(7, 5, 6), 1'b0, '0);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (stim_rows[i]) send_beat(stim_rows[i].req, stim_rows[i].has_exp,
                                       stim_rows[i].exp);
      drain();

      // full store: every index reachable, extra load ignored
      write_csrs(31'h7fffffff, 11'd0, 16'd1);
      for (int i = 0; i < MAX_POINTS; i++)
         send(load_req(i == 0, $urandom, $urandom, $urandom));
      send(load_req(1'b0, $urandom, $urandom, $urandom));
      send(hyp_req(1023, 512, $urandom_range(1023)));
      send(hyp_req($urandom_range(1023), 1022, 1021));
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: write_csrs(31'd0, 11'd0, 16'd3);
            1: write_csrs(31'($urandom_range(1 << 14, 1 << 20)), 11'd1, 16'd0);
            2: write_csrs(31'h7fffffff, 11'd1024, 16'd65535);
            3: write_csrs(31'($urandom_range(1 << 12, 1 << 18)), 11'd2, 16'd5);
            4: write_csrs(31'($urandom), 11'($urandom_range(4)), 16'($urandom_range(1, 7)));
            default: write_csrs(31'd65536, 11'd0, 16'd1);
         endcase
         idle_pct = ph < 2 ? 15 : (ph < 4 ? 64 : 0);
         total = n_loads + n_hyps;
         while (n_loads + n_hyps - total < 85) begin
            if ($urandom_range(7) == 0) send(rand_hyp());
            else plane_sequence();
            if ($urandom_range(15) == 0) drain();
         end
         drain();
      end

      $display("%0d loads, %0d hypotheses (%0d zero-denominator, %0d new best) checked",
               n_loads, n_hyps, n_rejects, n_updates);
      $display("thresholds from 0 to max, min_inliers 0..1024, round lengths 0..65535");
      if (mismatches == 0 && failures == 0 && expected_scores.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches, %0d other failures", mismatches, failures);
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
